// File: rtl/core/cld_pkg.sv
// ----------------------------------------------------------------------------
// cld_pkg
// Shared constants for the CRLF line deframer.
// ----------------------------------------------------------------------------
package cld_pkg;

  localparam int MAX_LINE = 64;
  localparam int ADDR_W   = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;

  localparam logic       CMD_BYTE  = 1'b0;
  localparam logic       CMD_ERROR = 1'b1;

  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;

  localparam logic [6:0] MAX_FILL  = 7'(MAX_LINE);

endpackage

// File: rtl/core/crlf_line_deframer.sv
// ----------------------------------------------------------------------------
// crlf_line_deframer
// Assembles received bytes into CR LF terminated lines and emits each clean,
// non-empty line one word per byte, the final word marked with out_last.
// ----------------------------------------------------------------------------
// An input word is taken whenever no line is being read out.
// A byte ahead of the two-byte delay is written to a 64 x 8 single-port line
// store; when a clean line ends, input is held off and the store is read
// back byte by byte, each byte through a read state and then an output
// state, so a line blocks the input until its last byte is accepted.
// Corrupted symbols and overflow past the store depth drop the line.
module crlf_line_deframer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_cmd,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_line_byte,
  output logic [5:0] out_byte_index,
  output logic [6:0] out_line_length,
  output logic       out_last
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_SHOW  = 2'd2;

  logic [7:0] line_mem [cld_pkg::MAX_LINE];

  logic [1:0] state_r, state_nxt;
  logic [7:0] db0_r, db0_nxt, db1_r, db1_nxt;
  logic [1:0] dv_r, dv_nxt;
  logic [6:0] fill_r, fill_nxt;
  logic       good_r, good_nxt;
  logic       ended_r, ended_nxt;
  logic [cld_pkg::ADDR_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [7:0] rd_data_r;

  logic       in_acc, out_acc;
  logic       wr_en;
  logic [cld_pkg::ADDR_W-1:0] wr_addr;
  logic [1:0] dv_cur;
  logic [6:0] fill_cur;
  logic       good_cur;
  logic       emit;
  logic       at_last;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_SHOW);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign at_last   = ({1'b0, 6'(rd_idx_r)} + 7'd1) == fill_r;

  assign out_line_byte   = rd_data_r;
  assign out_byte_index  = 6'(rd_idx_r);
  assign out_line_length = fill_r;
  assign out_last        = at_last;

  always_comb begin
    dv_cur    = ended_r ? 2'b00 : dv_r;
    fill_cur  = ended_r ? 7'd0 : fill_r;
    good_cur  = ended_r ? 1'b1 : good_r;
    wr_en     = 1'b0;
    wr_addr   = fill_cur[cld_pkg::ADDR_W-1:0];
    db0_nxt   = db0_r;
    db1_nxt   = db1_r;
    dv_nxt    = dv_r;
    fill_nxt  = fill_r;
    good_nxt  = good_r;
    ended_nxt = ended_r;
    emit      = 1'b0;
    if (in_acc) begin
      if (in_cmd == cld_pkg::CMD_ERROR) begin
        good_nxt = 1'b0;
      end else begin
        fill_nxt = fill_cur;
        good_nxt = good_cur;
        if (fill_cur < cld_pkg::MAX_FILL) begin
          if (dv_cur[0]) begin
            wr_en    = 1'b1;
            fill_nxt = fill_cur + 7'd1;
          end
        end else begin
          good_nxt = 1'b0;
        end
        db0_nxt   = db1_r;
        db1_nxt   = in_data_byte;
        dv_nxt    = {1'b1, dv_cur[1]};
        ended_nxt = dv_cur[1] && (db1_r == cld_pkg::CHAR_CR) &&
                    (in_data_byte == cld_pkg::CHAR_LF);
        emit      = good_nxt && ended_nxt && (fill_nxt != 7'd0);
      end
    end
  end

  always_comb begin
    state_nxt  = state_r;
    rd_idx_nxt = rd_idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (emit) begin
          state_nxt  = ST_ISSUE;
          rd_idx_nxt = '0;
        end
      end
      ST_ISSUE: state_nxt = ST_SHOW;
      ST_SHOW: begin
        if (out_acc) begin
          if (at_last) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt  = ST_ISSUE;
            rd_idx_nxt = rd_idx_r + {{(cld_pkg::ADDR_W-1){1'b0}}, 1'b1};
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      dv_r     <= 2'b00;
      fill_r   <= 7'd0;
      good_r   <= 1'b1;
      ended_r  <= 1'b1;
      rd_idx_r <= '0;
    end else begin
      state_r  <= state_nxt;
      dv_r     <= dv_nxt;
      fill_r   <= fill_nxt;
      good_r   <= good_nxt;
      ended_r  <= ended_nxt;
      rd_idx_r <= rd_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    db0_r <= db0_nxt;
    db1_r <= db1_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[wr_addr] <= db0_r;
    end
    if (state_r == ST_ISSUE) begin
      rd_data_r <= line_mem[rd_idx_r];
    end
  end

  a_no_input_during_readout: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input accepted while a line is read out");

  a_last_matches_length: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_line_length == ({1'b0, out_byte_index} + 7'd1)))
    else $error("last word does not close the line length");

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= cld_pkg::MAX_FILL)
    else $error("fill count beyond store depth");

  a_read_before_show: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=> (!out_valid && !in_ready))
    else $error("next word shown without a store read");

  a_index_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=> ##1
      (out_byte_index == $past(out_byte_index, 2) + 6'd1))
    else $error("byte index did not advance by one");

endmodule
